// ===== rtl/rthsl_pkg.sv =====
// Shared widths and the per-stage word carried along the divider chain.
// No dependencies; imported by every module of the converter.
`timescale 1ns / 1ps
`default_nettype none
package rthsl_pkg;

    localparam int CHANNEL_BITS = 16;
    // hue divisor is 6*d, needs three bits more than a channel
    localparam int HUE_BITS     = CHANNEL_BITS + 3;
    localparam int WORD_BITS    = ((3 * CHANNEL_BITS + 7) / 8) * 8;

    typedef logic [CHANNEL_BITS-1:0] chan_t;
    typedef logic [HUE_BITS-1:0]     hue_t;

    typedef struct packed {
        logic  valid;
        logic  grey;
        chan_t light;
        chan_t s_rem;   // saturation partial remainder
        chan_t s_div;   // saturation divisor
        chan_t s_sh;    // dividend low bits out, quotient bits in
        hue_t  h_rem;   // hue partial remainder
        hue_t  h_div;   // hue divisor, 6*d
        chan_t h_sh;
    } stage_t;

endpackage
`default_nettype wire

// ===== rtl/rgb_to_hsl_16bit_core.sv =====
// Top level of the RGB to HSL converter: front stage, divider chain, output register.
// Depends on rthsl_pkg, rthsl_front and rthsl_cell.
`timescale 1ns / 1ps
`default_nettype none
// Converts one RGB word of three 16-bit channels per clock, while the chain is not
// stalled, into hue, saturation and lightness. Lightness is the floor mean of the
// largest and smallest channel; saturation and hue are exact floor quotients
// produced by two restoring dividers that run side by side through a row of
// CHANNEL_BITS identical cells, one quotient bit per cell. Throughput is one word
// per clock while not stalled; each word passes the front stage, 16 cells and the
// output register. The whole chain advances together: it stalls only while the
// output register is full and m_tready is low, and s_tready reflects that directly.
// Grey pixels (all channels equal) give hue and saturation of zero.
module rgb_to_hsl_16bit_core
    import rthsl_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [WORD_BITS-1:0] s_tdata,  // red_in, green_in, blue_in
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [WORD_BITS-1:0]      m_tdata   // hue_out, saturation_out, lightness_out
);

    stage_t chain [CHANNEL_BITS+1];
    logic   advance;
    logic   out_valid_reg;
    logic [WORD_BITS-1:0] out_data_reg;
    logic [WORD_BITS-1:0] out_data_next;

    // chain moves whenever the output register is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;

    rthsl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (s_tvalid),
        .red       (s_tdata[CHANNEL_BITS-1:0]),
        .green     (s_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS]),
        .blue      (s_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS]),
        .stage_reg (chain[0])
    );

    for (genvar i = 0; i < CHANNEL_BITS; i++)
    begin : g_cell
        rthsl_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .prev      (chain[i]),
            .stage_reg (chain[i+1])
        );
    end

    always_comb
    begin
        out_data_next = '0;
        out_data_next[CHANNEL_BITS-1:0] =
            chain[CHANNEL_BITS].grey ? '0 : chain[CHANNEL_BITS].h_sh;
        out_data_next[2*CHANNEL_BITS-1:CHANNEL_BITS] =
            chain[CHANNEL_BITS].grey ? '0 : chain[CHANNEL_BITS].s_sh;
        out_data_next[3*CHANNEL_BITS-1:2*CHANNEL_BITS] = chain[CHANNEL_BITS].light;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= chain[CHANNEL_BITS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

// ===== rtl/rthsl_front.sv =====
// Front stage: max/min, lightness, divisors and dividend split per pixel.
// Depends on rthsl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rthsl_front
    import rthsl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   en,
    input  wire logic   in_valid,
    input  wire chan_t  red,
    input  wire chan_t  green,
    input  wire chan_t  blue,
    output stage_t      stage_reg
);

    stage_t stage_next;
    chan_t  mx;
    chan_t  mn;
    chan_t  d;
    logic [CHANNEL_BITS:0] sum;
    chan_t  den;
    hue_t   dx;
    hue_t   num;
    hue_t   nm1;
    localparam logic [CHANNEL_BITS:0] FS = {1'b0, {CHANNEL_BITS{1'b1}}};
    localparam logic [CHANNEL_BITS:0] FS2 = {{CHANNEL_BITS{1'b1}}, 1'b0};

    always_comb
    begin
        mx  = (red >= green) ? red : green;
        mx  = (mx >= blue) ? mx : blue;
        mn  = (red <= green) ? red : green;
        mn  = (mn <= blue) ? mn : blue;
        d   = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};
        den = (sum < FS) ? sum[CHANNEL_BITS-1:0] : CHANNEL_BITS'(FS2 - sum);
        dx  = HUE_BITS'(d);

        // sector position times d, in 0..6d-1; red wins ties, then green
        if (red >= green && red >= blue)
        begin
            if (green >= blue)
                num = HUE_BITS'(green) - HUE_BITS'(blue);
            else
                num = (dx << 2) + (dx << 1) - (HUE_BITS'(blue) - HUE_BITS'(green));
        end
        else if (green >= blue)
            num = (dx << 1) + HUE_BITS'(blue) - HUE_BITS'(red);
        else
            num = (dx << 2) + HUE_BITS'(red) - HUE_BITS'(green);
        nm1 = num - 1'b1;

        // FS*x = ((x-1) << CB) + (2^CB - x): high part seeds the remainder
        // hue x can pass 2^CB: high part is x - ceil(x / 2^CB),
        // low part is -x mod 2^CB
        stage_next.valid = in_valid;
        stage_next.grey  = (d == '0);
        stage_next.light = sum[CHANNEL_BITS:1];
        stage_next.s_div = den;
        stage_next.s_rem = (d == '0) ? '0 : d - 1'b1;
        stage_next.s_sh  = ~d + 1'b1;
        stage_next.h_div = (dx << 2) + (dx << 1);
        stage_next.h_rem = (num == '0) ? '0 : nm1 - (nm1 >> CHANNEL_BITS);
        stage_next.h_sh  = ~num[CHANNEL_BITS-1:0] + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= '0;
        else if (en)
            stage_reg <= stage_next;
    end

endmodule
`default_nettype wire

// ===== rtl/rthsl_cell.sv =====
// One restoring-division cell: one quotient bit for saturation and hue.
// Depends on rthsl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rthsl_cell
    import rthsl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   en,
    input  wire stage_t prev,
    output stage_t      stage_reg
);

    stage_t stage_next;
    logic [CHANNEL_BITS:0] s_shift;
    logic [HUE_BITS:0]     h_shift;
    logic                  s_ge;
    logic                  h_ge;

    always_comb
    begin
        s_shift = {prev.s_rem, prev.s_sh[CHANNEL_BITS-1]};
        s_ge    = s_shift >= {1'b0, prev.s_div};
        h_shift = {prev.h_rem, prev.h_sh[CHANNEL_BITS-1]};
        h_ge    = h_shift >= {1'b0, prev.h_div};

        stage_next       = prev;
        stage_next.s_rem = s_ge ? CHANNEL_BITS'(s_shift - {1'b0, prev.s_div})
                                : s_shift[CHANNEL_BITS-1:0];
        stage_next.s_sh  = {prev.s_sh[CHANNEL_BITS-2:0], s_ge};
        stage_next.h_rem = h_ge ? HUE_BITS'(h_shift - {1'b0, prev.h_div})
                                : h_shift[HUE_BITS-1:0];
        stage_next.h_sh  = {prev.h_sh[CHANNEL_BITS-2:0], h_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= '0;
        else if (en)
            stage_reg <= stage_next;
    end

endmodule
`default_nettype wire
